>>> rtl/rsa_mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA modular exponentiation package
// Shared constants, register indexes, controller states and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
package rsa_mexp_pkg;

   // Fixed field widths
   localparam int MSG_BITS      = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 2;

   // Default datapath width
   localparam int MODULUS_BITS_DEF = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODULUS     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PUBLIC_EXP  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIVATE_EXP = 2'd2;

   // Register reset values
   localparam logic [CSR_DATA_BITS-1:0] MODULUS_RST     = 32'd1;
   localparam logic [CSR_DATA_BITS-1:0] PUBLIC_EXP_RST  = 32'd65537;
   localparam logic [CSR_DATA_BITS-1:0] PRIVATE_EXP_RST = 32'd0;

   // Opcode values
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REDUCE,
      ST_EXP,
      ST_MUL_RUN,
      ST_MUL_WB,
      ST_SQR_RUN,
      ST_SQR_WB,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // capture operands, prepare reduction
      logic set_one;     // zero exponent: answer one
      logic set_zero;    // zero modulus: answer zero
      logic red_step;    // one bit of the input reduction
      logic mul_load;    // start a modular multiply
      logic mul_sq;      // operands for the multiply: base by base
      logic mul_step;    // one bit of the multiply
      logic wb_result;   // write product into result
      logic wb_base;     // write product into base
      logic expo_shift;  // drop the low exponent bit
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic expo_zero;
      logic expo_bit0;
      logic mod_zero;
      logic cnt_zero;
   } status_type;

endpackage

>>> rtl/rsa_mexp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA modular exponentiation datapath
// Operand registers, bit-serial input reduction and a shared shift-and-add
// modular multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
module rsa_mexp_dp #(
   parameter int MODULUS_BITS = rsa_mexp_pkg::MODULUS_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  rsa_mexp_pkg::cmd_type                    cmd,
   output rsa_mexp_pkg::status_type                 status,
   input  logic                                     opcode,
   input  logic [rsa_mexp_pkg::MSG_BITS-1:0]        message_value,
   input  logic [rsa_mexp_pkg::CSR_DATA_BITS-1:0]   modulus,
   input  logic [rsa_mexp_pkg::CSR_DATA_BITS-1:0]   public_exponent,
   input  logic [rsa_mexp_pkg::CSR_DATA_BITS-1:0]   private_exponent,
   output logic [rsa_mexp_pkg::MSG_BITS-1:0]        result_value
);
   import rsa_mexp_pkg::*;

   localparam int DW    = MODULUS_BITS;
   localparam int CMAX  = (DW > MSG_BITS) ? DW : MSG_BITS;
   localparam int CW    = $clog2(CMAX);
   localparam logic [CW-1:0] RED_LAST = CW'(MSG_BITS - 1);
   localparam logic [CW-1:0] MUL_LAST = CW'(DW - 1);

   logic [DW-1:0]            mod_ff, mod_in;
   logic [DW-1:0]            base_ff, base_in;
   logic [DW-1:0]            res_ff, res_in;
   logic [DW-1:0]            acc_ff, acc_in;
   logic [DW-1:0]            x_ff, x_in;
   logic [DW-1:0]            y_ff, y_in;
   logic [CSR_DATA_BITS-1:0] expo_ff, expo_in;
   logic [MSG_BITS-1:0]      msg_ff, msg_in;
   logic [CW-1:0]            cnt_ff, cnt_in;

   logic [DW-1:0] mod_new;
   logic [DW:0]   red_sum, acc_sum, x_sum, mod_ext;
   logic [DW-1:0] red_mod, acc_mod, x_mod;

   assign mod_new = DW'(modulus);
   assign mod_ext = {1'b0, mod_ff};

   // Reduction step: r = (2r + bit) mod m
   assign red_sum = {base_ff, msg_ff[MSG_BITS-1]};
   assign red_mod = (red_sum >= mod_ext) ? DW'(red_sum - mod_ext) : DW'(red_sum);

   // Multiply step: acc += x when y bit set, x doubles, both mod m
   assign acc_sum = {1'b0, acc_ff} + {1'b0, x_ff};
   assign acc_mod = (acc_sum >= mod_ext) ? DW'(acc_sum - mod_ext) : DW'(acc_sum);
   assign x_sum   = {x_ff, 1'b0};
   assign x_mod   = (x_sum >= mod_ext) ? DW'(x_sum - mod_ext) : DW'(x_sum);

   // Next-state selection
   always_comb begin
      mod_in  = mod_ff;
      base_in = base_ff;
      res_in  = res_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      expo_in = expo_ff;
      msg_in  = msg_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         mod_in  = mod_new;
         base_in = '0;
         res_in  = (mod_new == DW'(1)) ? '0 : DW'(1);
         expo_in = (opcode == OP_DECRYPT) ? private_exponent : public_exponent;
         msg_in  = message_value;
         cnt_in  = RED_LAST;
      end
      if (cmd.set_one) begin
         res_in = DW'(1);
      end
      if (cmd.set_zero) begin
         res_in = '0;
      end
      if (cmd.red_step) begin
         base_in = red_mod;
         msg_in  = {msg_ff[MSG_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
      end
      if (cmd.wb_result) begin
         res_in = acc_ff;
      end
      if (cmd.wb_base) begin
         base_in = acc_ff;
      end
      if (cmd.expo_shift) begin
         expo_in = {1'b0, expo_ff[CSR_DATA_BITS-1:1]};
      end
      if (cmd.mul_load) begin
         acc_in = '0;
         x_in   = cmd.mul_sq ? base_ff : res_ff;
         y_in   = base_ff;
         cnt_in = MUL_LAST;
      end
      if (cmd.mul_step) begin
         acc_in = y_ff[0] ? acc_mod : acc_ff;
         x_in   = x_mod;
         y_in   = {1'b0, y_ff[DW-1:1]};
         cnt_in = cnt_ff - CW'(1);
      end
   end

   // Hold operands
   always_ff @(posedge clock) begin
      mod_ff  <= mod_in;
      base_ff <= base_in;
      res_ff  <= res_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      expo_ff <= expo_in;
      msg_ff  <= msg_in;
      cnt_ff  <= cnt_in;
   end

   assign status.expo_zero = (expo_ff == '0);
   assign status.expo_bit0 = expo_ff[0];
   assign status.mod_zero  = (mod_ff == '0);
   assign status.cnt_zero  = (cnt_ff == '0);

   assign result_value = MSG_BITS'(res_ff);

   // Reduced base stays below the modulus
   a_base_reduced: assert property (@(posedge clock) disable iff (reset)
      (cmd.red_step || cmd.wb_base) && !status.mod_zero |=> base_ff < mod_ff)
      else $error("base not reduced");

   // Partial product stays below the modulus
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_step && !status.mod_zero |=> acc_ff < mod_ff)
      else $error("partial product not reduced");

   // Write-back only once the multiply has run all its bits
   a_wb_after_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.wb_result || cmd.wb_base) |-> $past(cmd.mul_step) && $past(status.cnt_zero))
      else $error("write-back before multiply finished");

endmodule

>>> rtl/rsa_mexp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA modular exponentiation controller
// Sequences load, input reduction and the square-and-multiply loop over the
// exponent bits, low bit first.
// ----------------------------------------------------------------------------
module rsa_mexp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     done,
   output rsa_mexp_pkg::cmd_type    cmd,
   input  rsa_mexp_pkg::status_type status
);
   import rsa_mexp_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.expo_zero) begin
               cmd.set_one = 1'b1;
               state_in    = ST_DONE;
            end else if (status.mod_zero) begin
               cmd.set_zero = 1'b1;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            priority if (status.expo_zero) begin
               state_in = ST_DONE;
            end else if (status.expo_bit0) begin
               cmd.mul_load = 1'b1;
               state_in     = ST_MUL_RUN;
            end else begin
               cmd.mul_load = 1'b1;
               cmd.mul_sq   = 1'b1;
               state_in     = ST_SQR_RUN;
            end
         end
         ST_MUL_RUN: begin
            cmd.mul_step = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_MUL_WB;
            end
         end
         ST_MUL_WB: begin
            // squaring reads only the base, so it may load alongside
            cmd.wb_result = 1'b1;
            cmd.mul_load  = 1'b1;
            cmd.mul_sq    = 1'b1;
            state_in      = ST_SQR_RUN;
         end
         ST_SQR_RUN: begin
            cmd.mul_step = 1'b1;
            if (status.cnt_zero) begin
               state_in = ST_SQR_WB;
            end
         end
         ST_SQR_WB: begin
            cmd.wb_base    = 1'b1;
            cmd.expo_shift = 1'b1;
            state_in       = ST_EXP;
         end
         ST_DONE: begin
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An accepted word always starts the operand load
   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_CHECK)
      else $error("accepted word not loaded");

   // Result strobe lasts one cycle
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done |=> !done && !busy)
      else $error("result strobe held");

endmodule

>>> rtl/rsa_modular_exponentiation_top.sv
`timescale 1ns / 1ps
// Run time from start to rsp_valid grows with the exponent bit length and its set bits;
//   a zero exponent or modulus skips the reduction and the square-and-multiply loop.
// Throughput: one word at a time, the next taken in the cycle after rsp_valid; the shift-and-add
//   multiplier, one bit per cycle, sets it.
// Reset: synchronous, active high; controller idles, config registers take their reset values.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// RSA modular exponentiation top level
// Configuration registers, controller and datapath for value^exponent mod
// modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_top #(
   parameter int MODULUS_BITS = rsa_mexp_pkg::MODULUS_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_opcode,
   input  logic [rsa_mexp_pkg::MSG_BITS-1:0]        req_message_value,
   output logic                                     rsp_valid,
   output logic [rsa_mexp_pkg::MSG_BITS-1:0]        rsp_result_value,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [rsa_mexp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rsa_mexp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rsa_mexp_pkg::*;

   logic [CSR_DATA_BITS-1:0] modulus_ff, pub_exp_ff, priv_exp_ff;
   cmd_type                  cmd;
   status_type               status;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= MODULUS_RST;
         pub_exp_ff  <= PUBLIC_EXP_RST;
         priv_exp_ff <= PRIVATE_EXP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODULUS:     modulus_ff  <= csr_wdata;
            CSR_PUBLIC_EXP:  pub_exp_ff  <= csr_wdata;
            CSR_PRIVATE_EXP: priv_exp_ff <= csr_wdata;
            default: begin
               // unmapped index: drop the word
            end
         endcase
      end
   end

   rsa_mexp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .done   (rsp_valid),
      .cmd    (cmd),
      .status (status)
   );

   rsa_mexp_dp #(
      .MODULUS_BITS (MODULUS_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .opcode           (req_opcode),
      .message_value    (req_message_value),
      .modulus          (modulus_ff),
      .public_exponent  (pub_exp_ff),
      .private_exponent (priv_exp_ff),
      .result_value     (rsp_result_value)
   );

   // Result strobe comes only from a running command
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

endmodule
